// ===== rtl/core/ehti_pkg.sv =====
// Shared types and constants for the edge hash table insert block.
package ehti_pkg;

  localparam int ADDR_WIDTH = 48;
  localparam int CTX_WIDTH = 16;
  localparam int TIME_WIDTH = 64;
  localparam int READ_BIN_WIDTH = 13;
  localparam int WAY_FIELD_WIDTH = 2;
  // wide enough for the largest supported bin count
  localparam int BIN_IDX_WIDTH = 16;
  localparam int DIGIT_BITS = 4;
  localparam int HASH_STEPS = ADDR_WIDTH / DIGIT_BITS;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [READ_BIN_WIDTH-1:0] READ_BIN_MASK = 13'h1FFF;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_REJECTED = 3'd3,
    ST_READ     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_REJECT = 2'd2
  } op_t;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] src_addr;
    logic [CTX_WIDTH-1:0]  src_ctx;
    logic [TIME_WIDTH-1:0] src_time;
    logic [ADDR_WIDTH-1:0] sink_addr;
    logic [CTX_WIDTH-1:0]  sink_ctx;
    logic [TIME_WIDTH-1:0] sink_time;
  } edge_t;

  typedef struct packed {
    op_t                        op;
    logic [BIN_IDX_WIDTH-1:0]   bin;
    logic [WAY_FIELD_WIDTH-1:0] way;
    edge_t                      data;
  } req_t;

endpackage

// ===== rtl/core/ehti_front.sv =====
// Front end: takes requests, classifies them and computes the bin number.
module ehti_front #(
  parameter int BIN_COUNT = 8192
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   clearing,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   kind,
  input  logic [ehti_pkg::ADDR_WIDTH-1:0]        src_addr,
  input  logic [ehti_pkg::CTX_WIDTH-1:0]         src_ctx,
  input  logic [ehti_pkg::TIME_WIDTH-1:0]        src_time,
  input  logic [ehti_pkg::ADDR_WIDTH-1:0]        sink_addr,
  input  logic [ehti_pkg::CTX_WIDTH-1:0]         sink_ctx,
  input  logic [ehti_pkg::TIME_WIDTH-1:0]        sink_time,
  input  logic [ehti_pkg::READ_BIN_WIDTH-1:0]    read_bin,
  input  logic [ehti_pkg::WAY_FIELD_WIDTH-1:0]   read_way,
  output logic                                   push,
  output ehti_pkg::req_t                         push_data,
  input  logic                                   q_full
);
  import ehti_pkg::*;

  localparam int BW = $clog2(BIN_COUNT);
  localparam bit POW2 = (BIN_COUNT & (BIN_COUNT - 1)) == 0;

  logic                  accept;
  logic                  hold_valid;
  req_t                  hold;
  req_t                  req_in;
  logic [ADDR_WIDTH-1:0] key_in;
  logic [BW-1:0]         bin;
  logic                  bin_ready;

  assign accept   = in_valid && in_ready;
  assign push     = hold_valid && bin_ready && !q_full;
  assign in_ready = !clearing && (!hold_valid || push);

  always_comb begin
    req_in.data.src_addr  = src_addr;
    req_in.data.src_ctx   = src_ctx;
    req_in.data.src_time  = src_time;
    req_in.data.sink_addr = sink_addr;
    req_in.data.sink_ctx  = sink_ctx;
    req_in.data.sink_time = sink_time;
    req_in.way            = read_way;
    req_in.bin            = '0;
    if (kind) begin
      req_in.op = OP_READ;
    end else if (src_addr == '0) begin
      req_in.op = OP_REJECT;
    end else begin
      req_in.op = OP_INSERT;
    end
    if (kind) begin
      key_in = ADDR_WIDTH'(read_bin & READ_BIN_MASK);
    end else begin
      key_in = src_addr ^ sink_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
    if (accept) begin
      hold <= req_in;
    end
  end

  generate
    if (POW2) begin : g_mask
      logic [ADDR_WIDTH-1:0] key;

      always_ff @(posedge clk) begin
        if (accept) begin
          key <= key_in;
        end
      end

      assign bin       = key[BW-1:0];
      assign bin_ready = 1'b1;
    end else begin : g_rem
      // residue fold: each nibble times its weight 16^i mod BIN_COUNT, reduced
      // per nibble; the partial residues are registered, then summed and reduced
      localparam int PW = BW + DIGIT_BITS;
      localparam logic [PW-1:0] MODV = PW'(BIN_COUNT);

      logic [ADDR_WIDTH-1:0] key;
      logic                  key_ok;
      logic [BW-1:0]         part      [HASH_STEPS];
      logic [BW-1:0]         part_next [HASH_STEPS];
      logic [BW-1:0]         rem;

      function automatic logic [BW-1:0] nibble_weight(int pos);
        logic [PW-1:0] wgt;
        wgt = PW'(1);
        for (int j = 0; j < pos * DIGIT_BITS; j++) begin
          wgt = wgt << 1;
          if (wgt >= MODV) begin
            wgt = wgt - MODV;
          end
        end
        return wgt[BW-1:0];
      endfunction

      function automatic logic [BW-1:0] fold_nibble(logic [DIGIT_BITS-1:0] nib,
                                                    logic [BW-1:0] wgt);
        logic [PW-1:0] prod;
        prod = PW'(nib) * PW'(wgt);
        for (int s = DIGIT_BITS - 1; s >= 0; s--) begin
          if (prod >= (MODV << s)) begin
            prod = prod - (MODV << s);
          end
        end
        return prod[BW-1:0];
      endfunction

      for (genvar i = 0; i < HASH_STEPS; i++) begin : g_nib
        localparam logic [BW-1:0] WGT = nibble_weight(i);
        assign part_next[i] = fold_nibble(key[i*DIGIT_BITS +: DIGIT_BITS], WGT);
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          key_ok <= 1'b0;
        end else begin
          key_ok <= !accept;
        end
        if (accept) begin
          key <= key_in;
        end
        for (int i = 0; i < HASH_STEPS; i++) begin
          part[i] <= part_next[i];
        end
      end

      always_comb begin
        logic [PW-1:0] acc;
        acc = '0;
        for (int i = 0; i < HASH_STEPS; i++) begin
          acc = acc + PW'(part[i]);
        end
        for (int s = DIGIT_BITS - 1; s >= 0; s--) begin
          if (acc >= (MODV << s)) begin
            acc = acc - (MODV << s);
          end
        end
        rem = acc[BW-1:0];
      end

      assign bin       = rem;
      assign bin_ready = key_ok;
    end
  endgenerate

  always_comb begin
    push_data     = hold;
    push_data.bin = BIN_IDX_WIDTH'(bin);
  end

endmodule

// ===== rtl/core/ehti_fifo.sv =====
// Short request queue between the front end and the table engine.
module ehti_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ehti_pkg::req_t push_data,
  output logic           full,
  input  logic           pop,
  output ehti_pkg::req_t pop_data,
  output logic           empty
);
  import ehti_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  req_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = count == CW'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("request queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("request queue underflow");

endmodule

// ===== rtl/core/ehti_back.sv =====
// Table engine: reads a bin row, searches its ways, writes back and forms the result.
module ehti_back #(
  parameter int BIN_COUNT = 8192,
  parameter int BIN_WAYS  = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  output logic                                  clearing,
  input  logic                                  q_empty,
  input  ehti_pkg::req_t                        q_head,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0]                            status,
  output logic [ehti_pkg::WAY_FIELD_WIDTH-1:0]  slot_way,
  output logic                                  entry_valid,
  output logic [ehti_pkg::ADDR_WIDTH-1:0]       out_src_addr,
  output logic [ehti_pkg::CTX_WIDTH-1:0]        out_src_ctx,
  output logic [ehti_pkg::TIME_WIDTH-1:0]       out_src_time,
  output logic [ehti_pkg::ADDR_WIDTH-1:0]       out_sink_addr,
  output logic [ehti_pkg::CTX_WIDTH-1:0]        out_sink_ctx,
  output logic [ehti_pkg::TIME_WIDTH-1:0]       out_sink_time
);
  import ehti_pkg::*;

  localparam int BW = $clog2(BIN_COUNT);
  localparam int WW = (BIN_WAYS > 1) ? $clog2(BIN_WAYS) : 1;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_EVAL
  } state_t;

  state_t               state;
  logic [BW-1:0]        clr_idx;
  req_t                 cur;
  logic                 commit;
  logic [BW-1:0]        rd_bin;
  logic [BW-1:0]        cur_bin;

  logic [BIN_WAYS-1:0]  used_mem [BIN_COUNT];
  logic [BIN_WAYS-1:0]  used_rd;
  logic                 used_we;
  logic [BW-1:0]        used_wa;
  logic [BIN_WAYS-1:0]  used_wd;
  edge_t                way_rd [BIN_WAYS];
  logic [BIN_WAYS-1:0]  way_we;

  logic                 found;
  logic                 is_new;
  logic [WW-1:0]        hit_way;
  logic                 sel_used;
  edge_t                sel;
  logic                 ins_commit;

  status_t              res_status;
  logic [WAY_FIELD_WIDTH-1:0] res_way;
  logic                 res_valid;
  edge_t                res_data;

  status_t              out_status;
  edge_t                out_data;

  assign clearing = state == B_CLEAR;
  assign pop      = state == B_IDLE && !q_empty;
  assign commit   = state == B_EVAL && (!out_valid || out_ready);
  assign rd_bin   = q_head.bin[BW-1:0];
  assign cur_bin  = cur.bin[BW-1:0];

  // way search: first free way or first matching used way, lowest first
  always_comb begin
    found    = 1'b0;
    is_new   = 1'b0;
    hit_way  = '0;
    sel_used = 1'b0;
    sel      = '0;
    for (int w = 0; w < BIN_WAYS; w++) begin
      if (!found) begin
        if (!used_rd[w]) begin
          found   = 1'b1;
          is_new  = 1'b1;
          hit_way = WW'(w);
        end else if (way_rd[w].src_addr == cur.data.src_addr &&
                     way_rd[w].sink_addr == cur.data.sink_addr &&
                     way_rd[w].src_ctx == cur.data.src_ctx &&
                     way_rd[w].sink_ctx == cur.data.sink_ctx) begin
          found   = 1'b1;
          hit_way = WW'(w);
        end
      end
      // out-of-range read way never matches and reads as empty
      if (int'(cur.way) == w) begin
        sel_used = used_rd[w];
        sel      = way_rd[w];
      end
    end
  end

  assign ins_commit = commit && cur.op == OP_INSERT && found;

  // an update rewrites the whole entry: the keys already match
  always_comb begin
    for (int w = 0; w < BIN_WAYS; w++) begin
      way_we[w] = ins_commit && hit_way == WW'(w);
    end
  end

  always_comb begin
    used_we = clearing || (ins_commit && is_new);
    used_wa = clearing ? clr_idx : cur_bin;
    used_wd = clearing ? '0 : (used_rd | way_we);
  end

  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    if (pop) begin
      used_rd <= used_mem[rd_bin];
    end
  end

  generate
    for (genvar w = 0; w < BIN_WAYS; w++) begin : g_way
      edge_t mem [BIN_COUNT];

      always_ff @(posedge clk) begin
        if (way_we[w]) begin
          mem[cur_bin] <= cur.data;
        end
        if (pop) begin
          way_rd[w] <= mem[rd_bin];
        end
      end
    end
  endgenerate

  always_comb begin
    res_way   = '0;
    res_valid = 1'b0;
    res_data  = '0;
    case (cur.op)
      OP_READ: begin
        res_status = ST_READ;
        res_way    = cur.way;
        res_valid  = sel_used;
        res_data   = sel_used ? sel : '0;
      end
      OP_INSERT: begin
        if (found) begin
          res_status = is_new ? ST_INSERTED : ST_UPDATED;
          res_way    = WAY_FIELD_WIDTH'(hit_way);
        end else begin
          res_status = ST_DROPPED;
        end
      end
      default: begin
        res_status = ST_REJECTED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !commit) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_CLEAR: begin
          clr_idx <= clr_idx + BW'(1);
          if (clr_idx == BW'(BIN_COUNT - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop) begin
            cur   <= q_head;
            state <= B_EVAL;
          end
        end
        B_EVAL: begin
          if (commit) begin
            out_valid   <= 1'b1;
            out_status  <= res_status;
            slot_way    <= res_way;
            entry_valid <= res_valid;
            out_data    <= res_data;
            state       <= B_IDLE;
          end
        end
        default: begin
          state <= B_CLEAR;
        end
      endcase
    end
  end

  assign status        = out_status;
  assign out_src_addr  = out_data.src_addr;
  assign out_src_ctx   = out_data.src_ctx;
  assign out_src_time  = out_data.src_time;
  assign out_sink_addr = out_data.sink_addr;
  assign out_sink_ctx  = out_data.sink_ctx;
  assign out_sink_time = out_data.sink_time;

  // a pop is always followed by B_EVAL and its write-back, so the next read sees it
  a_pop_spacing: assert property (@(posedge clk) disable iff (rst) pop |=> !pop)
    else $error("back-to-back bin reads");
  a_insert_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_READ |-> !entry_valid)
    else $error("entry_valid set on insert result");

endmodule

// ===== rtl/core/edge_hash_table_insert.sv =====
// Top level of the edge hash table: front end, request queue and table engine.
//
// Input channel (in_valid/in_ready) carries one request: kind 0 inserts or
// updates an edge, kind 1 reads one way of one bin. Output channel
// (out_valid/out_ready) returns exactly one result per request, in order.
// Insert hashes src_addr ^ sink_addr modulo BIN_COUNT to a bin; the lowest
// free way takes a new edge, a matching way gets its timestamps rewritten,
// a full bin drops the edge, a zero source address is rejected.
// A request is registered in the front end, waits in the queue, is read from
// the table by the table engine and lands in the output register; with a
// non-power-of-two BIN_COUNT the residue fold adds its register of partial
// residues and holds the front end until the bin is ready. The table engine
// reads a bin row on a pop and writes it back with the result, before it
// pops again. Reset: the valid-bit memory is cleared one bin per cycle, with
// in_ready low. When the receiver stalls the result is held in the output
// register, one more request waits in the table engine, up to two in the
// queue and one in the front end, after which in_ready drops.
module edge_hash_table_insert #(
  parameter int BIN_COUNT = 8192,
  parameter int BIN_WAYS  = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 kind,
  input  logic [ehti_pkg::ADDR_WIDTH-1:0]      src_addr,
  input  logic [ehti_pkg::CTX_WIDTH-1:0]       src_ctx,
  input  logic [ehti_pkg::TIME_WIDTH-1:0]      src_time,
  input  logic [ehti_pkg::ADDR_WIDTH-1:0]      sink_addr,
  input  logic [ehti_pkg::CTX_WIDTH-1:0]       sink_ctx,
  input  logic [ehti_pkg::TIME_WIDTH-1:0]      sink_time,
  input  logic [ehti_pkg::READ_BIN_WIDTH-1:0]  read_bin,
  input  logic [ehti_pkg::WAY_FIELD_WIDTH-1:0] read_way,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           status,
  output logic [ehti_pkg::WAY_FIELD_WIDTH-1:0] slot_way,
  output logic                                 entry_valid,
  output logic [ehti_pkg::ADDR_WIDTH-1:0]      out_src_addr,
  output logic [ehti_pkg::CTX_WIDTH-1:0]       out_src_ctx,
  output logic [ehti_pkg::TIME_WIDTH-1:0]      out_src_time,
  output logic [ehti_pkg::ADDR_WIDTH-1:0]      out_sink_addr,
  output logic [ehti_pkg::CTX_WIDTH-1:0]       out_sink_ctx,
  output logic [ehti_pkg::TIME_WIDTH-1:0]      out_sink_time
);
  import ehti_pkg::*;

  logic clearing;
  logic push;
  req_t push_data;
  logic q_full;
  logic q_empty;
  logic pop;
  req_t q_head;

  ehti_front #(
    .BIN_COUNT(BIN_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .src_addr  (src_addr),
    .src_ctx   (src_ctx),
    .src_time  (src_time),
    .sink_addr (sink_addr),
    .sink_ctx  (sink_ctx),
    .sink_time (sink_time),
    .read_bin  (read_bin),
    .read_way  (read_way),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  ehti_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_head),
    .empty     (q_empty)
  );

  ehti_back #(
    .BIN_COUNT(BIN_COUNT),
    .BIN_WAYS (BIN_WAYS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .clearing      (clearing),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .slot_way      (slot_way),
    .entry_valid   (entry_valid),
    .out_src_addr  (out_src_addr),
    .out_src_ctx   (out_src_ctx),
    .out_src_time  (out_src_time),
    .out_sink_addr (out_sink_addr),
    .out_sink_ctx  (out_sink_ctx),
    .out_sink_time (out_sink_time)
  );

endmodule

// ===== verif/edge_hash_table_insert_tb.sv =====
// Self-checking testbench for the edge hash table insert and read block.
module edge_hash_table_insert_tb;
  import ehti_pkg::*;

  localparam int TB_BINS      = 8192;
  localparam int TB_WAYS      = 4;
  localparam int SLOTS        = TB_BINS * TB_WAYS;
  localparam int RANDOM_REQS  = 930;
  localparam int HOT_BINS     = 16;
  localparam int POOL_MAX     = 128;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic                       kind;
    logic [ADDR_WIDTH-1:0]      src_addr;
    logic [CTX_WIDTH-1:0]       src_ctx;
    logic [TIME_WIDTH-1:0]      src_time;
    logic [ADDR_WIDTH-1:0]      sink_addr;
    logic [CTX_WIDTH-1:0]       sink_ctx;
    logic [TIME_WIDTH-1:0]      sink_time;
    logic [READ_BIN_WIDTH-1:0]  read_bin;
    logic [WAY_FIELD_WIDTH-1:0] read_way;
  } edge_request_t;

  typedef struct {
    status_t                    status;
    logic [WAY_FIELD_WIDTH-1:0] way;
    logic                       valid;
    edge_t                      data;
  } edge_result_t;

  typedef struct {
    logic [ADDR_WIDTH-1:0] src_addr;
    logic [ADDR_WIDTH-1:0] sink_addr;
    logic [CTX_WIDTH-1:0]  src_ctx;
    logic [CTX_WIDTH-1:0]  sink_ctx;
  } edge_key_t;

  class edge_table_scoreboard;
    bit           slot_used [SLOTS];
    edge_t        stored_edge [SLOTS];
    int           used_slots [$];
    edge_result_t pending_results [$];
    int           errors;
    int           checked;
    int           by_status [5];

    // Walks the bin in way order, exactly as the table does.
    function void note_request(edge_request_t rq);
      edge_result_t r;
      int bin;
      int slot;
      bit done;
      r.status = ST_READ;
      r.way = '0;
      r.valid = 1'b0;
      r.data = '0;
      if (rq.kind) begin
        slot = int'(rq.read_bin) * TB_WAYS + int'(rq.read_way);
        r.way = rq.read_way;
        if (slot_used[slot]) begin
          r.valid = 1'b1;
          r.data = stored_edge[slot];
        end
      end else if (rq.src_addr == '0) begin
        r.status = ST_REJECTED;
      end else begin
        bin = int'((rq.src_addr ^ rq.sink_addr) % TB_BINS);
        r.status = ST_DROPPED;
        done = 1'b0;
        for (int w = 0; w < TB_WAYS; w++) begin
          slot = bin * TB_WAYS + w;
          if (!done && slot_used[slot]) begin
            if (stored_edge[slot].src_addr == rq.src_addr &&
                stored_edge[slot].sink_addr == rq.sink_addr &&
                stored_edge[slot].src_ctx == rq.src_ctx &&
                stored_edge[slot].sink_ctx == rq.sink_ctx) begin
              stored_edge[slot].src_time = rq.src_time;
              stored_edge[slot].sink_time = rq.sink_time;
              r.status = ST_UPDATED;
              r.way = w[WAY_FIELD_WIDTH-1:0];
              done = 1'b1;
            end
          end else if (!done) begin
            stored_edge[slot] = '{rq.src_addr, rq.src_ctx, rq.src_time,
                                  rq.sink_addr, rq.sink_ctx, rq.sink_time};
            slot_used[slot] = 1'b1;
            used_slots.push_back(slot);
            r.status = ST_INSERTED;
            r.way = w[WAY_FIELD_WIDTH-1:0];
            done = 1'b1;
          end
        end
      end
      by_status[int'(r.status)]++;
      pending_results.push_back(r);
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch on result %0d, %0s: got %0h, expected %0h",
               checked, field, got, want);
      errors++;
    endtask

    task check_result(edge_result_t seen);
      edge_result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result", 64'(seen.status), 64'(0));
      end else begin
        want = pending_results.pop_front();
        if (seen.status !== want.status)
          report("status", 64'(seen.status), 64'(want.status));
        if (seen.way !== want.way) report("slot_way", 64'(seen.way), 64'(want.way));
        if (seen.valid !== want.valid)
          report("entry_valid", 64'(seen.valid), 64'(want.valid));
        if (seen.data.src_addr !== want.data.src_addr)
          report("out_src_addr", 64'(seen.data.src_addr), 64'(want.data.src_addr));
        if (seen.data.src_ctx !== want.data.src_ctx)
          report("out_src_ctx", 64'(seen.data.src_ctx), 64'(want.data.src_ctx));
        if (seen.data.src_time !== want.data.src_time)
          report("out_src_time", seen.data.src_time, want.data.src_time);
        if (seen.data.sink_addr !== want.data.sink_addr)
          report("out_sink_addr", 64'(seen.data.sink_addr), 64'(want.data.sink_addr));
        if (seen.data.sink_ctx !== want.data.sink_ctx)
          report("out_sink_ctx", 64'(seen.data.sink_ctx), 64'(want.data.sink_ctx));
        if (seen.data.sink_time !== want.data.sink_time)
          report("out_sink_time", seen.data.sink_time, want.data.sink_time);
      end
      checked++;
    endtask
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic                       kind;
  logic [ADDR_WIDTH-1:0]      src_addr;
  logic [CTX_WIDTH-1:0]       src_ctx;
  logic [TIME_WIDTH-1:0]      src_time;
  logic [ADDR_WIDTH-1:0]      sink_addr;
  logic [CTX_WIDTH-1:0]       sink_ctx;
  logic [TIME_WIDTH-1:0]      sink_time;
  logic [READ_BIN_WIDTH-1:0]  read_bin;
  logic [WAY_FIELD_WIDTH-1:0] read_way;
  logic                       out_valid;
  logic                       out_ready;
  logic [2:0]                 status;
  logic [WAY_FIELD_WIDTH-1:0] slot_way;
  logic                       entry_valid;
  logic [ADDR_WIDTH-1:0]      out_src_addr;
  logic [CTX_WIDTH-1:0]       out_src_ctx;
  logic [TIME_WIDTH-1:0]      out_src_time;
  logic [ADDR_WIDTH-1:0]      out_sink_addr;
  logic [CTX_WIDTH-1:0]       out_sink_ctx;
  logic [TIME_WIDTH-1:0]      out_sink_time;

  edge_table_scoreboard sb;
  int  cycle_count;
  bit  in_idle;
  bit  out_idle;
  int  hot_bin [HOT_BINS];
  edge_key_t key_pool [$];

  edge_hash_table_insert DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .src_addr(src_addr), .src_ctx(src_ctx), .src_time(src_time),
    .sink_addr(sink_addr), .sink_ctx(sink_ctx), .sink_time(sink_time),
    .read_bin(read_bin), .read_way(read_way),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .slot_way(slot_way), .entry_valid(entry_valid),
    .out_src_addr(out_src_addr), .out_src_ctx(out_src_ctx),
    .out_src_time(out_src_time), .out_sink_addr(out_sink_addr),
    .out_sink_ctx(out_sink_ctx), .out_sink_time(out_sink_time)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [ADDR_WIDTH-1:0] rand_addr();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[ADDR_WIDTH-1:0];
  endfunction

  function automatic logic [TIME_WIDTH-1:0] rand_time();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CTX_WIDTH-1:0] rand_ctx();
    return CTX_WIDTH'($urandom);
  endfunction

  function automatic edge_request_t insert_req(logic [ADDR_WIDTH-1:0] sa,
                                               logic [CTX_WIDTH-1:0] sc,
                                               logic [TIME_WIDTH-1:0] st,
                                               logic [ADDR_WIDTH-1:0] ka,
                                               logic [CTX_WIDTH-1:0] kc,
                                               logic [TIME_WIDTH-1:0] kt);
    edge_request_t rq;
    rq.kind = 1'b0;
    rq.src_addr = sa;
    rq.src_ctx = sc;
    rq.src_time = st;
    rq.sink_addr = ka;
    rq.sink_ctx = kc;
    rq.sink_time = kt;
    // bin and way are don't-care on an insert
    rq.read_bin = READ_BIN_WIDTH'($urandom);
    rq.read_way = WAY_FIELD_WIDTH'($urandom);
    return rq;
  endfunction

  function automatic edge_request_t read_req(int bin, int way);
    edge_request_t rq;
    rq = insert_req(rand_addr(), rand_ctx(), rand_time(), rand_addr(), rand_ctx(),
                    rand_time());
    rq.kind = 1'b1;
    rq.read_bin = bin[READ_BIN_WIDTH-1:0];
    rq.read_way = way[WAY_FIELD_WIDTH-1:0];
    return rq;
  endfunction

  task automatic send_request(edge_request_t rq);
    int gap;
    gap = in_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind <= rq.kind;
    src_addr <= rq.src_addr;
    src_ctx <= rq.src_ctx;
    src_time <= rq.src_time;
    sink_addr <= rq.sink_addr;
    sink_ctx <= rq.sink_ctx;
    sink_time <= rq.sink_time;
    read_bin <= rq.read_bin;
    read_way <= rq.read_way;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rq);
    @(negedge clk);
  endtask

  task automatic send_key(edge_key_t k);
    send_request(insert_req(k.src_addr, k.src_ctx, rand_time(), k.sink_addr,
                            k.sink_ctx, rand_time()));
  endtask

  // Bin 0 gets filled, updated, overflowed and read back; then the top bin.
  task automatic run_directed();
    logic [ADDR_WIDTH-1:0] a1;
    logic [TIME_WIDTH-1:0] t1;
    a1 = '1;
    t1 = '1;
    send_request(insert_req('0, 16'hFFFF, t1, a1, 16'hFFFF, t1));
    send_request(insert_req(a1, 16'hFFFF, t1, a1, 16'hFFFF, t1));
    send_request(insert_req(a1, 16'hFFFF, '0, a1, 16'hFFFF, '0));
    send_request(read_req(0, 0));
    send_request(insert_req(48'h1, 16'h0, 64'h1, 48'h1, 16'h0, 64'h2));
    send_request(insert_req(48'h2000, 16'h1, t1, 48'h2000, 16'h1, '0));
    send_request(insert_req(48'h8000_0000_0000, 16'h8000, 64'h8000_0000_0000_0000,
                            48'h8000_0000_0000, 16'h8000, 64'h1));
    send_request(insert_req(48'h4000, 16'h2, rand_time(), 48'h4000, 16'h2,
                            rand_time()));
    // same addresses as way 0, one context off: no match
    send_request(insert_req(a1, 16'h7FFF, '0, a1, 16'hFFFF, '0));
    send_request(insert_req(a1, 16'hFFFF, '0, a1, 16'hFFFE, '0));
    send_request(insert_req(48'h8000_0000_0000, 16'h8000, 64'h1234_5678_9ABC_DEF0,
                            48'h8000_0000_0000, 16'h8000, t1));
    for (int w = 0; w < TB_WAYS; w++) send_request(read_req(0, w));
    send_request(insert_req(48'h1FFF, 16'h0, '0, '0, 16'h0, '0));
    send_request(read_req(TB_BINS - 1, 0));
    send_request(insert_req('0, '0, '0, '0, '0, '0));
  endtask

  // Mostly traffic aimed at a few crowded bins so that updates and drops happen.
  task automatic run_random(int count);
    edge_key_t k;
    int pick;
    int slot;
    for (int n = 0; n < count; n++) begin
      if (n % 200 == 0)
        foreach (hot_bin[i]) hot_bin[i] = $urandom_range(0, TB_BINS - 1);
      if (n % 60 == 0) in_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 30 && key_pool.size() > 0) begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        case ($urandom_range(0, 9))
          0: k.src_ctx[$urandom_range(0, CTX_WIDTH - 1)] ^= 1'b1;
          1: k.sink_ctx[$urandom_range(0, CTX_WIDTH - 1)] ^= 1'b1;
          2: k.sink_addr[$urandom_range(13, ADDR_WIDTH - 1)] ^= 1'b1;
          default: ;
        endcase
        send_key(k);
      end else if (pick < 55) begin
        do k.src_addr = rand_addr(); while (k.src_addr == '0);
        k.sink_addr = rand_addr();
        k.sink_addr[12:0] = k.src_addr[12:0] ^ 13'(hot_bin[$urandom_range(0, HOT_BINS - 1)]);
        k.src_ctx = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3));
        k.sink_ctx = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3));
        if (key_pool.size() >= POOL_MAX) void'(key_pool.pop_front());
        key_pool.push_back(k);
        send_key(k);
      end else if (pick < 65) begin
        send_request(insert_req(rand_addr(), rand_ctx(), rand_time(), rand_addr(),
                                rand_ctx(), rand_time()));
      end else if (pick < 70) begin
        send_request(insert_req('0, rand_ctx(), rand_time(), rand_addr(), rand_ctx(),
                                rand_time()));
      end else if (sb.used_slots.size() > 0) begin
        slot = sb.used_slots[$urandom_range(0, sb.used_slots.size() - 1)];
        send_request(read_req(slot / TB_WAYS, slot % TB_WAYS));
      end else begin
        send_request(insert_req(rand_addr() | 48'h1, rand_ctx(), rand_time(),
                                rand_addr(), rand_ctx(), rand_time()));
      end
    end
  endtask

  initial begin
    int gap;
    int served;
    out_ready = 1'b0;
    out_idle = 1'b1;
    served = 0;
    forever begin
      if (served % 40 == 0) out_idle = ($urandom_range(0, 3) != 0);
      gap = out_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid || rst);
      served++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : watch_results
    edge_result_t seen;
    if (!rst && out_valid && out_ready) begin
      seen.status = status_t'(status);
      seen.way = slot_way;
      seen.valid = entry_valid;
      seen.data = '{out_src_addr, out_src_ctx, out_src_time,
                    out_sink_addr, out_sink_ctx, out_sink_time};
      sb.check_result(seen);
    end
  end

  initial begin
    sb = new();
    in_idle = 1'b1;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = 1'b0;
    src_addr = '0;
    src_ctx = '0;
    src_time = '0;
    sink_addr = '0;
    sink_ctx = '0;
    sink_time = '0;
    read_bin = '0;
    read_way = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(RANDOM_REQS);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("requests: %0d inserted, %0d updated, %0d dropped, %0d rejected, %0d reads",
             sb.by_status[ST_INSERTED], sb.by_status[ST_UPDATED],
             sb.by_status[ST_DROPPED], sb.by_status[ST_REJECTED], sb.by_status[ST_READ]);
    $display("results checked: %0d, mismatches: %0d", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
